// File: rtl/core/link_status_led_animator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the link status LED animator
// Concurrent checks clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LINK_STATUS_LED_ANIMATOR_UNIT_ASSERT_SVH
`define LINK_STATUS_LED_ANIMATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define LSLA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsla assertion failed");

// next-cycle implication
`define LSLA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsla assertion failed");

`endif

// File: rtl/core/lsla_pkg.sv
// ----------------------------------------------------------------------------
// lsla_pkg
// Types, codes and constants shared by the link status LED animator.
// ----------------------------------------------------------------------------
package lsla_pkg;

	typedef enum logic [2:0] {
		FUNC_SERVICE = 3'd0,
		FUNC_SET     = 3'd1,
		FUNC_TX      = 3'd2,
		FUNC_RX      = 3'd3,
		FUNC_WARN    = 3'd4,
		FUNC_ERROR   = 3'd5,
		FUNC_ALIVE   = 3'd6
	} func_t;

	// link state codes; codes above ST_ERROR may be stored and are passed through
	localparam logic [2:0] ST_BOOT      = 3'd0;
	localparam logic [2:0] ST_READY     = 3'd1;
	localparam logic [2:0] ST_CONNECTED = 3'd2;
	localparam logic [2:0] ST_LOST      = 3'd3;
	localparam logic [2:0] ST_ERROR     = 3'd4;

	typedef enum logic [2:0] {
		PULSE_NONE  = 3'd0,
		PULSE_TX    = 3'd1,
		PULSE_RX    = 3'd2,
		PULSE_WARN  = 3'd3,
		PULSE_ERROR = 3'd4
	} pulse_t;

	localparam int unsigned PHASE_W = 10;

	localparam logic [31:0] TX_PULSE_MS    = 32'd80;
	localparam logic [31:0] RX_PULSE_MS    = 32'd80;
	localparam logic [31:0] WARN_PULSE_MS  = 32'd120;
	localparam logic [31:0] ERROR_PULSE_MS = 32'd150;
	localparam logic [31:0] MS_PER_STEP    = 32'd10;
	// ceil(2^35 / 10): dt * RECIP10 >> 35 is dt / 10 for every 32-bit dt
	localparam logic [31:0] RECIP10        = 32'hCCCC_CCCD;
	localparam logic [31:0] TIMEOUT_RESET  = 32'd600;
	localparam logic [7:0]  ERROR_BLINK_LEVEL = 8'd180;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] now_ms;
		logic [2:0]  new_link_state;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [2:0] current_state;
	} result_t;

	// handed from the state update to the colour stage
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [2:0]         link_state;
		pulse_t             pulse;
	} colour_req_t;

endpackage

// File: rtl/core/lsla_step.sv
// ----------------------------------------------------------------------------
// lsla_step
// Animator state: phase, link state, pulse end times, alive and service marks.
// ----------------------------------------------------------------------------
module lsla_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_data,
	input  logic                 fire,
	input  lsla_pkg::item_t      item,
	output lsla_pkg::colour_req_t req
);
	import lsla_pkg::*;

	logic [31:0]        timeout_q;
	logic [2:0]         link_state_q;
	logic [31:0]        last_service_q;
	logic [PHASE_W-1:0] phase_q;
	logic [31:0]        tx_end_q;
	logic [31:0]        rx_end_q;
	logic [31:0]        warn_end_q;
	logic [31:0]        error_end_q;
	logic [31:0]        last_alive_q;

	logic [31:0]        dt;
	logic [63:0]        prod;
	logic [PHASE_W-1:0] step;
	logic [PHASE_W-1:0] incr;
	logic [PHASE_W-1:0] phase_next;
	logic [31:0]        alive_age;
	logic [2:0]         state_next;
	pulse_t             pulse;

	assign dt   = item.now_ms - last_service_q;
	assign prod = {32'd0, dt} * {32'd0, RECIP10};
	// only the low bits of the quotient matter, the phase wraps
	assign step = (dt < MS_PER_STEP) ? PHASE_W'(1) : prod[35 +: PHASE_W];

	always_comb begin
		unique case (link_state_q)
			ST_BOOT:      incr = (step << 1) + (step << 2);
			ST_READY:     incr = step << 1;
			ST_LOST:      incr = step << 2;
			ST_ERROR:     incr = (step << 1) + (step << 3);
			default:      incr = step + (step << 1);
		endcase
	end

	assign phase_next = phase_q + incr;
	assign alive_age  = item.now_ms - last_alive_q;

	always_comb begin
		state_next = link_state_q;
		if ((link_state_q == ST_READY || link_state_q == ST_CONNECTED)
				&& alive_age > timeout_q) begin
			state_next = ST_LOST;
		end
	end

	always_comb begin
		if (item.now_ms < error_end_q) begin
			pulse = PULSE_ERROR;
		end else if (item.now_ms < warn_end_q) begin
			pulse = PULSE_WARN;
		end else if (item.now_ms < rx_end_q) begin
			pulse = PULSE_RX;
		end else if (item.now_ms < tx_end_q) begin
			pulse = PULSE_TX;
		end else begin
			pulse = PULSE_NONE;
		end
	end

	assign req.phase      = phase_next;
	assign req.link_state = state_next;
	assign req.pulse      = pulse;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_state_q   <= ST_BOOT;
			last_service_q <= '0;
			phase_q        <= '0;
			tx_end_q       <= '0;
			rx_end_q       <= '0;
			warn_end_q     <= '0;
			error_end_q    <= '0;
			last_alive_q   <= '0;
		end else if (fire) begin
			unique case (item.func)
				FUNC_SERVICE: begin
					last_service_q <= item.now_ms;
					phase_q        <= phase_next;
					link_state_q   <= state_next;
				end
				FUNC_SET:   link_state_q <= item.new_link_state;
				FUNC_TX:    tx_end_q     <= item.now_ms + TX_PULSE_MS;
				FUNC_RX:    rx_end_q     <= item.now_ms + RX_PULSE_MS;
				FUNC_WARN:  warn_end_q   <= item.now_ms + WARN_PULSE_MS;
				FUNC_ERROR: error_end_q  <= item.now_ms + ERROR_PULSE_MS;
				FUNC_ALIVE: last_alive_q <= item.now_ms;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/lsla_colour.sv
// ----------------------------------------------------------------------------
// lsla_colour
// Triangle-wave base colour per link state with pulse override.
// ----------------------------------------------------------------------------
module lsla_colour (
	input  lsla_pkg::colour_req_t req,
	output lsla_pkg::result_t     rsp
);
	import lsla_pkg::*;

	logic [7:0]  amp;
	logic [15:0] third_prod;
	logic [7:0]  low;
	logic [7:0]  mid;

	// upper half of the phase runs down: (1023 - p) >> 1 is ~p[8:1]
	assign amp        = req.phase[9] ? ~req.phase[8:1] : req.phase[8:1];
	// a / 3 as a * 171 >> 9, exact for 8-bit a
	assign third_prod = {8'd0, amp} * 16'd171;
	assign low        = {1'b0, third_prod[15:9]};
	assign mid        = {1'b0, amp[7:1]};

	always_comb begin
		rsp.red           = 8'd0;
		rsp.green         = 8'd0;
		rsp.blue          = 8'd0;
		rsp.current_state = req.link_state;
		case (req.link_state)
			ST_BOOT:      rsp.blue = mid;
			ST_READY: begin
				rsp.green = low;
				rsp.blue  = low;
			end
			ST_CONNECTED: rsp.green = mid;
			ST_LOST: begin
				rsp.red   = mid;
				rsp.green = {1'b0, mid[7:1]};
			end
			ST_ERROR:     rsp.red = (amp > ERROR_BLINK_LEVEL) ? 8'd255 : 8'd0;
			default: ;
		endcase
		unique case (req.pulse)
			PULSE_ERROR: begin
				rsp.red   = 8'd255;
				rsp.green = 8'd0;
				rsp.blue  = 8'd0;
			end
			PULSE_WARN: begin
				rsp.red   = 8'd255;
				rsp.green = 8'd80;
				rsp.blue  = 8'd0;
			end
			PULSE_RX: begin
				rsp.red   = 8'd160;
				rsp.green = 8'd0;
				rsp.blue  = 8'd255;
			end
			PULSE_TX: begin
				rsp.red   = 8'd255;
				rsp.green = 8'd255;
				rsp.blue  = 8'd255;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/core/link_status_led_animator_unit.sv
// ----------------------------------------------------------------------------
// link_status_led_animator_unit
// Status LED colour engine: breathing colour per link state, pulse flashes.
// ----------------------------------------------------------------------------
// Use:
//   item channel (item_valid/item_stall/item) carries an operation, a ms
//   timestamp and a link state. Only a service operation produces a colour;
//   set, pulse and alive operations update state and produce nothing.
//   result channel (result_valid/result_stall/result) carries RGB and the link
//   state after the service step.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the lost timeout in ms;
//   it is always ready and should be written only while the block is idle.
// Timing:
//   an item enters the input register, the state update moves a service item
//   into the colour stage register, and its colour lands in the result
//   register. One item per cycle is taken, service or not, while item_stall
//   is low; the state recurrence runs combinationally through the dt/10
//   reciprocal multiply and phase adder.
// Reset: state clears to boot, all times and phase to zero, timeout to 600.
// Stall: a stalled result holds; the two stages behind it keep filling and
//   item_stall rises only when a service item has nowhere to go.
// ----------------------------------------------------------------------------
module link_status_led_animator_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lsla_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output lsla_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data
);
	import lsla_pkg::*;

	logic        vld_s1;
	item_t       item_s1;
	logic        vld_s2;
	colour_req_t req_s2;
	logic        vld_s3;
	result_t     rsp_s3;

	colour_req_t req;
	result_t     rsp;
	logic        is_service;
	logic        s3_free;
	logic        s2_free;
	logic        s1_fire;
	logic        accept;

	assign is_service = (item_s1.func == FUNC_SERVICE);
	assign s3_free    = !vld_s3 || !result_stall;
	assign s2_free    = !vld_s2 || s3_free;
	assign s1_fire    = vld_s1 && (!is_service || s2_free);
	assign item_stall = vld_s1 && !s1_fire;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	lsla_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.fire     (s1_fire),
		.item     (item_s1),
		.req      (req)
	);

	lsla_colour u_colour (
		.req (req_s2),
		.rsp (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (s1_fire) begin
				vld_s1 <= 1'b0;
			end
			if (s1_fire && is_service) begin
				vld_s2 <= 1'b1;
			end else if (s3_free) begin
				vld_s2 <= 1'b0;
			end
			if (vld_s2 && s3_free) begin
				vld_s3 <= 1'b1;
			end else if (!result_stall) begin
				vld_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (s1_fire && is_service) begin
			req_s2 <= req;
		end
		if (vld_s2 && s3_free) begin
			rsp_s3 <= rsp;
		end
	end

	assign result_valid = vld_s3;
	assign result       = rsp_s3;

endmodule

// File: rtl/core/lsla_checker.sv
// ----------------------------------------------------------------------------
// lsla_checker
// Port-level checks on the link status LED animator, bound to the top level.
// ----------------------------------------------------------------------------
module lsla_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input lsla_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input lsla_pkg::result_t result,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic [31:0]       cfg_data
);
	`include "link_status_led_animator_unit_assert.svh"

	// a stalled result holds until its transfer
	`LSLA_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
	// input back-pressure only ever comes from a full, stalled output
	`LSLA_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall)
	// configuration is never refused
	`LSLA_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)
	// every pulse colour has red; base colours without red are blue, green or cyan
	`LSLA_ASSERT_NOW(a_base_colour, result_valid && result.red == 8'd0, result.green == 8'd0 || result.blue == 8'd0 || result.green == result.blue)

endmodule

bind link_status_led_animator_unit lsla_checker u_lsla_checker (.*);
